>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the number token classifier
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked at every clock edge outside reset
`define NTC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ntc assertion failed");

// antecedent holds, consequent follows in the next cycle
`define NTC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ntc assertion failed");

`endif

>>> src/ntc_pkg.sv
// ----------------------------------------------------------------------------
// ntc_pkg
// shared types and character constants of the number token classifier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ntc_pkg;

   // class of a finished token
   typedef enum logic [1:0] {
      CLASS_NONE     = 2'd0,
      CLASS_INTEGER  = 2'd1,
      CLASS_RATIONAL = 2'd2,
      CLASS_FLOAT    = 2'd3
   } class_type;

   // ascii codes the recognizer looks for
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_EXP_UP = 8'h45;
   localparam logic [7:0] CHAR_EXP_LO = 8'h65;

   // control from the input stage to the recognizer
   typedef struct packed {
      logic advance;
      logic last;
   } step_type;

endpackage

>>> src/ntc_req_if.sv
// ----------------------------------------------------------------------------
// ntc_req_if
// byte channel into the classifier, one token byte per beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ntc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] token_char;
   logic       last_char;

   modport source (output valid, output token_char, output last_char, input ready);
   modport sink (input valid, input token_char, input last_char, output ready);
endinterface

>>> src/ntc_rsp_if.sv
// ----------------------------------------------------------------------------
// ntc_rsp_if
// result channel out of the classifier, one token class per beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ntc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] token_class;

   modport source (output valid, output token_class, input ready);
   modport sink (input valid, input token_class, output ready);
endinterface

>>> src/ntc_recognizer.sv
// ----------------------------------------------------------------------------
// ntc_recognizer
// token state register, next-state table and class decode
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ntc_recognizer (
   input  logic                clock,
   input  logic                reset,
   input  ntc_pkg::step_type   step,
   input  logic [7:0]          token_char,
   output ntc_pkg::class_type  token_class
);

   typedef enum logic [10:0] {
      ST_START   = 11'b000_0000_0001,
      ST_SIGN    = 11'b000_0000_0010,
      ST_INT     = 11'b000_0000_0100,
      ST_SLASH   = 11'b000_0000_1000,
      ST_DEN     = 11'b000_0001_0000,
      ST_DOT     = 11'b000_0010_0000,
      ST_FRAC    = 11'b000_0100_0000,
      ST_EXP     = 11'b000_1000_0000,
      ST_EXPSIGN = 11'b001_0000_0000,
      ST_EXPDIG  = 11'b010_0000_0000,
      ST_DEAD    = 11'b100_0000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;
   state_type next_state;
   logic      is_digit;
   logic      is_sign;
   logic      is_exp;

   assign is_digit = token_char inside {[ntc_pkg::CHAR_ZERO:ntc_pkg::CHAR_NINE]};
   assign is_sign  = token_char inside {ntc_pkg::CHAR_PLUS, ntc_pkg::CHAR_MINUS};
   assign is_exp   = token_char inside {ntc_pkg::CHAR_EXP_LO, ntc_pkg::CHAR_EXP_UP};

   always_comb begin
      next_state = ST_DEAD;
      case (state_ff)
         ST_START: begin
            if (is_sign) next_state = ST_SIGN;
            else if (is_digit) next_state = ST_INT;
            else if (token_char == ntc_pkg::CHAR_DOT) next_state = ST_DOT;
         end
         ST_SIGN: begin
            if (is_digit) next_state = ST_INT;
            else if (token_char == ntc_pkg::CHAR_DOT) next_state = ST_DOT;
         end
         ST_INT: begin
            if (is_digit) next_state = ST_INT;
            else if (token_char == ntc_pkg::CHAR_SLASH) next_state = ST_SLASH;
            else if (token_char == ntc_pkg::CHAR_DOT) next_state = ST_DOT;
            else if (is_exp) next_state = ST_EXP;
         end
         ST_SLASH, ST_DEN: begin
            if (is_digit) next_state = ST_DEN;
         end
         ST_DOT: begin
            if (is_digit) next_state = ST_FRAC;
         end
         ST_FRAC: begin
            if (is_digit) next_state = ST_FRAC;
            else if (is_exp) next_state = ST_EXP;
         end
         ST_EXP: begin
            if (is_sign) next_state = ST_EXPSIGN;
            else if (is_digit) next_state = ST_EXPDIG;
         end
         ST_EXPSIGN, ST_EXPDIG: begin
            if (is_digit) next_state = ST_EXPDIG;
         end
         default: next_state = ST_DEAD;
      endcase
   end

   // class of the token if this byte ends it
   always_comb begin
      case (next_state)
         ST_INT:             token_class = ntc_pkg::CLASS_INTEGER;
         ST_DEN:             token_class = ntc_pkg::CLASS_RATIONAL;
         ST_FRAC, ST_EXPDIG: token_class = ntc_pkg::CLASS_FLOAT;
         default:            token_class = ntc_pkg::CLASS_NONE;
      endcase
   end

   // back to start after the last byte
   always_comb begin
      state_in = state_ff;
      if (step.advance) begin
         state_in = step.last ? ST_START : next_state;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START;
      end else begin
         state_ff <= state_in;
      end
   end

   `NTC_ASSERT_NEXT(a_restart_after_last, clock, reset,
      step.advance && step.last, state_ff == ST_START)

endmodule

>>> src/ntc_out_reg.sv
// ----------------------------------------------------------------------------
// ntc_out_reg
// result register holding one token class until the sink takes it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ntc_out_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  ntc_pkg::class_type token_class,
   output logic               load_ok,
   ntc_rsp_if.source          rsp_chan
);

   logic               valid_ff;
   logic               valid_in;
   ntc_pkg::class_type class_ff;

   // free when empty or emptied this cycle
   assign load_ok  = !valid_ff || rsp_chan.ready;
   assign valid_in = load || (valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         class_ff <= token_class;
      end
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.token_class = class_ff;

   `NTC_ASSERT_NEXT(a_load_shows_valid, clock, reset, load, valid_ff)

endmodule

>>> src/number_token_classifier_top.sv
// ----------------------------------------------------------------------------
// number_token_classifier_top
// classifies a byte-serial token as none, integer, rational or float
// ----------------------------------------------------------------------------
// Takes one token byte per beat on req_chan, with last_char marking the
// final byte, and returns one class beat on rsp_chan per token: 0 none,
// 1 integer, 2 rational, 3 float. A byte is taken every cycle unless a
// last byte is held in the input register; a class is valid on rsp_chan
// once its last byte has passed the input register and then the result
// register. Per cycle the work is one lookup in the next-state table
// from the registered byte and the one-hot token state. Bytes that do not
// end a token never wait on rsp_chan; a last byte waits in the input
// register only while the result register holds a class not yet taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module number_token_classifier_top (
   input  logic       clock,
   input  logic       reset,
   ntc_req_if.sink    req_chan,
   ntc_rsp_if.source  rsp_chan
);

   // input register
   logic               in_valid_ff;
   logic               in_valid_in;
   logic [7:0]         char_ff;
   logic               last_ff;

   logic               accept;
   logic               advance;
   logic               load_ok;
   ntc_pkg::step_type  step;
   ntc_pkg::class_type token_class;

   // a byte moves on unless it ends a token and the result slot is busy
   assign advance        = in_valid_ff && (!last_ff || load_ok);
   assign req_chan.ready = !in_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;
   assign in_valid_in    = accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         char_ff <= req_chan.token_char;
         last_ff <= req_chan.last_char;
      end
   end

   assign step.advance = advance;
   assign step.last    = last_ff;

   ntc_recognizer u_recognizer (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .token_char  (char_ff),
      .token_class (token_class)
   );

   // result beat only on a token's last byte
   ntc_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .load        (advance && last_ff),
      .token_class (token_class),
      .load_ok     (load_ok),
      .rsp_chan    (rsp_chan)
   );

   // a held last byte blocks new bytes
   `NTC_ASSERT(a_stall_blocks_input, clock, reset,
      (in_valid_ff && last_ff && rsp_chan.valid && !rsp_chan.ready) |-> !req_chan.ready)

   // a fresh result beat comes only from a last byte moving on
   `NTC_ASSERT(a_result_from_last, clock, reset,
      $rose(rsp_chan.valid) |-> $past(advance && last_ff))

endmodule

>>> tb/number_token_classifier_top_test.sv
// ----------------------------------------------------------------------------
// number_token_classifier_top_test
// self-checking bench for the byte-serial numeric token classifier
// ----------------------------------------------------------------------------
// Feeds tokens one byte per beat and keeps its own copy of the lexer state.
// Each time a last byte is taken, the class that the token should get is
// queued. Every class beat that comes out is checked against that queue.
// Stimulus starts with short hand-picked tokens. It then runs three random
// phases with a different idle mix in each, each phase mixing well-formed
// numbers, damaged numbers and raw byte noise.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module number_token_classifier_top_test;

   // lexer states of the bench's own recognizer
   typedef enum logic [3:0] {
      LEX_START    = 4'd0,
      LEX_SIGN     = 4'd1,
      LEX_INT      = 4'd2,
      LEX_SLASH    = 4'd3,
      LEX_DEN      = 4'd4,
      LEX_DOT      = 4'd5,
      LEX_FRAC     = 4'd6,
      LEX_EXP      = 4'd7,
      LEX_EXP_SIGN = 4'd8,
      LEX_EXP_DIG  = 4'd9,
      LEX_DEAD     = 4'd10
   } lex_state_type;

   // shapes of generated numbers
   typedef enum int {
      FORM_INTEGER,
      FORM_RATIONAL,
      FORM_POINT_FLOAT,
      FORM_EXP_FLOAT
   } number_form_type;

   // ways to damage a well-formed number
   typedef enum int {
      DAMAGE_TRUNCATE,
      DAMAGE_REPLACE,
      DAMAGE_INSERT,
      DAMAGE_DELETE
   } damage_type;

   typedef logic [7:0] token_bytes_type [$];

   logic clock;
   logic reset;

   ntc_req_if req_chan ();
   ntc_rsp_if rsp_chan ();

   number_token_classifier_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // idle mix, in percent of cycles
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;

   // lexer state as the bench sees it, and the classes still owed
   lex_state_type      lexer_state = LEX_START;
   ntc_pkg::class_type expected_classes [$];

   int error_count = 0;
   int bytes_sent = 0;
   int tokens_sent = 0;
   int classes_checked = 0;
   int class_count [4] = '{0, 0, 0, 0};

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   // ---------------------------------------------------------------------
   // recognizer, the bench's own copy
   // ---------------------------------------------------------------------

   function automatic logic is_digit(input logic [7:0] ch);
      return ch >= ntc_pkg::CHAR_ZERO && ch <= ntc_pkg::CHAR_NINE;
   endfunction

   function automatic logic is_sign(input logic [7:0] ch);
      return ch == ntc_pkg::CHAR_PLUS || ch == ntc_pkg::CHAR_MINUS;
   endfunction

   function automatic logic is_exp_mark(input logic [7:0] ch);
      return ch == ntc_pkg::CHAR_EXP_UP || ch == ntc_pkg::CHAR_EXP_LO;
   endfunction

   // one step of the lexer; anything not listed falls into the dead state
   function automatic lex_state_type advance_lexer(input lex_state_type st,
                                                   input logic [7:0] ch);
      logic dig;
      dig = is_digit(ch);
      case (st)
         LEX_START: begin
            if (is_sign(ch)) return LEX_SIGN;
            if (dig) return LEX_INT;
            if (ch == ntc_pkg::CHAR_DOT) return LEX_DOT;
            return LEX_DEAD;
         end
         LEX_SIGN: begin
            // a sign must be followed by a digit or a point
            if (dig) return LEX_INT;
            if (ch == ntc_pkg::CHAR_DOT) return LEX_DOT;
            return LEX_DEAD;
         end
         LEX_INT: begin
            if (dig) return LEX_INT;
            if (ch == ntc_pkg::CHAR_SLASH) return LEX_SLASH;
            if (ch == ntc_pkg::CHAR_DOT) return LEX_DOT;
            if (is_exp_mark(ch)) return LEX_EXP;
            return LEX_DEAD;
         end
         // denominator is digits only, no sign
         LEX_SLASH, LEX_DEN: return dig ? LEX_DEN : LEX_DEAD;
         LEX_DOT: return dig ? LEX_FRAC : LEX_DEAD;
         LEX_FRAC: begin
            if (dig) return LEX_FRAC;
            if (is_exp_mark(ch)) return LEX_EXP;
            return LEX_DEAD;
         end
         LEX_EXP: begin
            if (is_sign(ch)) return LEX_EXP_SIGN;
            return dig ? LEX_EXP_DIG : LEX_DEAD;
         end
         LEX_EXP_SIGN, LEX_EXP_DIG: return dig ? LEX_EXP_DIG : LEX_DEAD;
         default: return LEX_DEAD;
      endcase
   endfunction

   // only states that closed on a digit give a number
   function automatic ntc_pkg::class_type class_for_state(input lex_state_type st);
      case (st)
         LEX_INT: return ntc_pkg::CLASS_INTEGER;
         LEX_DEN: return ntc_pkg::CLASS_RATIONAL;
         LEX_FRAC, LEX_EXP_DIG: return ntc_pkg::CLASS_FLOAT;
         default: return ntc_pkg::CLASS_NONE;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // mismatch reporting and result checking
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   // sink side: random stall, decided at the falling edge
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // every class beat is matched against the oldest owed class
   always @(posedge clock) begin : check_classes
      ntc_pkg::class_type owed;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_classes.size() == 0) begin
            report_mismatch($sformatf("class beat %0d with no token pending",
                                      rsp_chan.token_class));
         end else begin
            owed = expected_classes.pop_front();
            if (rsp_chan.token_class !== owed)
               report_mismatch($sformatf("token_class got %0d, want %0d (%s)",
                                         rsp_chan.token_class, owed, owed.name()));
            else
               classes_checked++;
         end
      end
   end

   // ---------------------------------------------------------------------
   // sending
   // ---------------------------------------------------------------------

   // drive one byte, hold it until taken, then update the lexer copy
   task automatic send_byte(input logic [7:0] ch, input logic is_last);
      lex_state_type nxt;
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.token_char <= ch;
      req_chan.last_char  <= is_last;
      do @(posedge clock); while (!req_chan.ready);
      bytes_sent++;
      nxt = advance_lexer(lexer_state, ch);
      if (is_last) begin
         // token done: owe its class, start over
         expected_classes.push_back(class_for_state(nxt));
         class_count[int'(class_for_state(nxt))]++;
         tokens_sent++;
         lexer_state = LEX_START;
      end else begin
         lexer_state = nxt;
      end
   endtask

   task automatic send_token(input token_bytes_type tok);
      for (int i = 0; i < tok.size(); i++)
         send_byte(tok[i], i == tok.size() - 1);
   endtask

   task automatic send_text(input string text);
      token_bytes_type tok;
      for (int i = 0; i < text.len(); i++)
         tok.push_back(text[i]);
      send_token(tok);
   endtask

   // stop sending and hold off until every owed class has come back
   task automatic wait_for_classes();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (expected_classes.size() != 0)
         @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // token builders
   // ---------------------------------------------------------------------

   function automatic void push_digits(ref token_bytes_type tok, input int lo,
                                       input int hi);
      repeat ($urandom_range(hi, lo))
         tok.push_back(ntc_pkg::CHAR_ZERO + 8'($urandom_range(9)));
   endfunction

   function automatic void push_exponent(ref token_bytes_type tok);
      tok.push_back($urandom_range(1) ? ntc_pkg::CHAR_EXP_UP : ntc_pkg::CHAR_EXP_LO);
      if ($urandom_range(1))
         tok.push_back($urandom_range(1) ? ntc_pkg::CHAR_PLUS : ntc_pkg::CHAR_MINUS);
      push_digits(tok, 1, 2);
   endfunction

   // a byte that is likely to matter to the lexer, sometimes any byte
   function automatic logic [7:0] pick_symbol();
      case ($urandom_range(7))
         0: return ntc_pkg::CHAR_PLUS;
         1: return ntc_pkg::CHAR_MINUS;
         2: return ntc_pkg::CHAR_DOT;
         3: return ntc_pkg::CHAR_SLASH;
         4: return ntc_pkg::CHAR_EXP_UP;
         5: return ntc_pkg::CHAR_EXP_LO;
         6: return ntc_pkg::CHAR_ZERO + 8'($urandom_range(9));
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic void build_number(ref token_bytes_type tok);
      number_form_type form;
      form = number_form_type'($urandom_range(3));
      if ($urandom_range(1))
         tok.push_back($urandom_range(1) ? ntc_pkg::CHAR_PLUS : ntc_pkg::CHAR_MINUS);
      case (form)
         FORM_INTEGER: push_digits(tok, 1, 5);
         FORM_RATIONAL: begin
            push_digits(tok, 1, 3);
            tok.push_back(ntc_pkg::CHAR_SLASH);
            push_digits(tok, 1, 3);
         end
         FORM_POINT_FLOAT: begin
            push_digits(tok, 0, 3);
            tok.push_back(ntc_pkg::CHAR_DOT);
            push_digits(tok, 1, 3);
            if ($urandom_range(1))
               push_exponent(tok);
         end
         default: begin
            push_digits(tok, 1, 3);
            push_exponent(tok);
         end
      endcase
   endfunction

   // may still come out well formed; the lexer copy decides either way
   function automatic void damage_number(ref token_bytes_type tok);
      damage_type how;
      how = damage_type'($urandom_range(3));
      case (how)
         DAMAGE_TRUNCATE: begin
            // cut-off tails give trailing separators and bare signs
            if (tok.size() > 1)
               repeat ($urandom_range(tok.size() - 1, 1)) void'(tok.pop_back());
            else
               tok[0] = pick_symbol();
         end
         DAMAGE_REPLACE: tok[$urandom_range(tok.size() - 1)] = pick_symbol();
         DAMAGE_INSERT: tok.insert($urandom_range(tok.size()), pick_symbol());
         default: begin
            if (tok.size() > 1)
               tok.delete($urandom_range(tok.size() - 1));
            else
               tok[0] = pick_symbol();
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // single-byte tokens, including the byte extremes
   task automatic test_single_bytes();
      token_bytes_type tok;
      send_text("7");
      send_text("+");
      send_text(".");
      tok = '{8'h00};
      send_token(tok);
      tok = '{8'hFF};
      send_token(tok);
   endtask

   // one clean token of each number class
   task automatic test_number_forms();
      send_text("-12");
      send_text("3/4");
      send_text("-.5");
      send_text("2E-3");
   endtask

   // signs with no digits and tokens ending on a separator
   task automatic test_edge_tokens();
      send_text("+/3");
      send_text("+e5");
      send_text("-.");
      send_text("5/");
      send_text("5.");
      send_text("5e+");
   endtask

   // mostly well-formed numbers, mixed with damaged ones and byte noise
   task automatic test_random_stream(input int send_pct, input int recv_pct,
                                     input int byte_target);
      token_bytes_type tok;
      int first_byte;
      int pick;
      sender_idle_pct    = send_pct;
      receiver_stall_pct = recv_pct;
      first_byte = bytes_sent;
      while (bytes_sent - first_byte < byte_target) begin
         tok.delete();
         pick = $urandom_range(99);
         if (pick < 60) begin
            build_number(tok);
         end else if (pick < 85) begin
            build_number(tok);
            damage_number(tok);
         end else begin
            repeat ($urandom_range(4, 1))
               tok.push_back(8'($urandom_range(255)));
         end
         send_token(tok);
      end
      // sender holds off until the sink has caught up
      wait_for_classes();
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------

   initial begin
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.token_char = 8'h00;
      req_chan.last_char  = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed tokens run under the first idle mix
      sender_idle_pct    = 7;
      receiver_stall_pct = 65;
      test_single_bytes();
      test_number_forms();
      test_edge_tokens();
      wait_for_classes();

      test_random_stream(7, 65, 265);
      test_random_stream(65, 7, 265);
      test_random_stream(0, 0, 285);

      // let any stray class beat show up before the verdict
      repeat (10) @(posedge clock);
      if (expected_classes.size() != 0)
         report_mismatch($sformatf("%0d token classes never came back",
                                   expected_classes.size()));

      $display("covered %0d tokens in %0d bytes: %0d none, %0d integer, %0d rational, %0d float",
               tokens_sent, bytes_sent, class_count[0], class_count[1],
               class_count[2], class_count[3]);
      $display("%0d class beats matched, %0d mismatches, three idle mixes",
               classes_checked, error_count);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

>>> files.f
+incdir+src
src/ntc_pkg.sv
src/ntc_req_if.sv
src/ntc_rsp_if.sv
src/ntc_recognizer.sv
src/ntc_out_reg.sv
src/number_token_classifier_top.sv
tb/number_token_classifier_top_test.sv
